@@ hw/rtl/swam_pkg.sv @@
// ----------------------------------------------------------------------------
// swam_pkg
// word types and kind codes shared by the sliding window anagram matcher
// ----------------------------------------------------------------------------
package swam_pkg;

	localparam int KIND_W   = 2;
	localparam int LETTER_W = 5;

	// number of letters, every one fits the letter field
	localparam int ALPHABET_SIZE = 26;

	// kind codes of an input word
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LETTER_W-1:0] letter;
	} in_word_t;

	typedef struct packed {
		logic window_match;
		logic found;
		logic overflow;
	} out_word_t;

endpackage

@@ hw/rtl/sliding_window_anagram_match.sv @@
// ----------------------------------------------------------------------------
// sliding_window_anagram_match
// streaming check whether the latest text window is a permutation of a pattern
// ----------------------------------------------------------------------------
// Usage
//   item channel (item_valid / item_stall / item): a clear word starts a query,
//   pattern words build the pattern, text words slide the window over the text.
//   result channel (result_valid / result_stall / result): one word per item,
//   carrying the window match of that item and the sticky found and overflow.
// Timing
//   an item is registered into the input stage at the edge it is accepted and
//   its result is loaded into the output register when the input stage
//   advances. one item is accepted every cycle while item_stall is low; the
//   per-letter count lanes and the mismatch check are updated together when
//   the item advances, and the ring of recent letters is read as the item is
//   registered so the leaving letter is ready when its item is processed.
// Reset and stall
//   reset empties both stages and clears the query (found reads 1 since the
//   pattern is empty). while result_stall holds a waiting result, one more
//   item is taken into the input stage, then item_stall rises until the
//   result is taken.
// ----------------------------------------------------------------------------
module sliding_window_anagram_match #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  swam_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output swam_pkg::out_word_t result
);
	import swam_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int DW = CW + 1;
	localparam int SW = $clog2(2 * MAX_WINDOW + 1);
	localparam logic [AW-1:0] WP_LAST = AW'(MAX_WINDOW - 1);
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_WINDOW);
	localparam logic [SW-1:0] RING_SPAN = SW'(MAX_WINDOW);

	// handshake
	logic      valid_s1;
	in_word_t  word_s1;
	logic      adv_s1;
	logic      item_fire;
	logic      res_valid_q;
	out_word_t res_q;

	// query state
	logic [CW-1:0] plen_q, plen_d;
	logic [CW-1:0] seen_q, seen_d;
	logic [AW-1:0] wp_q, wp_d;
	logic          found_q, found_d;
	logic          ovf_q, ovf_d;
	// per-letter window count minus pattern count
	logic [DW-1:0] diff_q [ALPHABET_SIZE];
	logic [DW-1:0] diff_d [ALPHABET_SIZE];

	// ring of recent text letters
	logic [LETTER_W-1:0] ring_q [MAX_WINDOW];
	logic [LETTER_W-1:0] ring_rd_s1;
	logic                byp_s1;
	logic [LETTER_W-1:0] byp_letter_s1;
	logic [LETTER_W-1:0] old_letter;
	logic [SW-1:0]       rd_sum;
	logic [AW-1:0]       rd_addr;
	logic                rd_hit;

	// decoded update
	logic clear;
	logic pat_upd;
	logic text_upd;
	logic full;
	logic empty_hit;
	logic letter_ok;
	logic old_ok;
	logic all_zero;
	logic match;

	assign adv_s1       = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !adv_s1;
	assign item_fire    = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign old_letter = byp_s1 ? byp_letter_s1 : ring_rd_s1;
	assign letter_ok  = 32'(word_s1.letter) < ALPHABET_SIZE;
	assign old_ok     = 32'(old_letter) < ALPHABET_SIZE;

	// decode the stage 1 word into scalar state updates
	always_comb begin
		plen_d    = plen_q;
		seen_d    = seen_q;
		wp_d      = wp_q;
		ovf_d     = ovf_q;
		clear     = 1'b0;
		pat_upd   = 1'b0;
		text_upd  = 1'b0;
		full      = 1'b0;
		empty_hit = 1'b0;
		if (adv_s1) begin
			case (word_s1.kind)
				KIND_CLEAR: begin
					clear  = 1'b1;
					plen_d = '0;
					seen_d = '0;
					wp_d   = '0;
					ovf_d  = 1'b0;
				end
				KIND_PATTERN: begin
					if (letter_ok && seen_q == '0 && wp_q == '0) begin
						if (plen_q >= LEN_MAX) begin
							ovf_d = 1'b1;
						end else begin
							pat_upd = 1'b1;
							plen_d  = plen_q + 1'b1;
						end
					end
				end
				KIND_TEXT: begin
					if (letter_ok) begin
						if (plen_q != '0) begin
							text_upd = 1'b1;
							full     = seen_q >= plen_q;
							if (!full)
								seen_d = seen_q + 1'b1;
							wp_d = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
						end else begin
							empty_hit = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// count lanes: new letter counts up, leaving letter and pattern letters count down
	always_comb begin
		all_zero = 1'b1;
		for (int c = 0; c < ALPHABET_SIZE; c++) begin
			if (clear) begin
				diff_d[c] = '0;
			end else begin
				diff_d[c] = diff_q[c]
					+ ((text_upd && 32'(word_s1.letter) == c) ? DW'(1) : DW'(0))
					- ((pat_upd && 32'(word_s1.letter) == c) ? DW'(1) : DW'(0))
					- ((full && old_ok && 32'(old_letter) == c) ? DW'(1) : DW'(0));
			end
			if (diff_d[c] != '0)
				all_zero = 1'b0;
		end
	end

	// window match and sticky found
	always_comb begin
		match   = empty_hit || (text_upd && seen_d == plen_q && all_zero);
		found_d = clear ? 1'b0 : (found_q || match);
	end

	// ring read address for the next item: oldest letter of the window
	always_comb begin
		rd_sum  = SW'(wp_d) + RING_SPAN - SW'(plen_d);
		rd_addr = (rd_sum >= RING_SPAN) ? AW'(rd_sum - RING_SPAN) : AW'(rd_sum);
		rd_hit  = text_upd && (wp_q == rd_addr);
	end

	// ring write
	always_ff @(posedge clk) begin
		if (text_upd)
			ring_q[wp_q] <= word_s1.letter;
	end

	// stage 1 payload and ring read
	always_ff @(posedge clk) begin
		if (item_fire) begin
			word_s1       <= item;
			ring_rd_s1    <= ring_q[rd_addr];
			byp_s1        <= rd_hit;
			byp_letter_s1 <= word_s1.letter;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q.window_match <= match;
			res_q.found        <= found_d || (plen_d == '0);
			res_q.overflow     <= ovf_d;
		end
	end

	// control and query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			plen_q      <= '0;
			seen_q      <= '0;
			wp_q        <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			for (int c = 0; c < ALPHABET_SIZE; c++)
				diff_q[c] <= '0;
		end else begin
			if (item_fire)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			plen_q  <= plen_d;
			seen_q  <= seen_d;
			wp_q    <= wp_d;
			found_q <= found_d;
			ovf_q   <= ovf_d;
			for (int c = 0; c < ALPHABET_SIZE; c++)
				diff_q[c] <= diff_d[c];
		end
	end

endmodule

@@ hw/rtl/swam_check.sv @@
// ----------------------------------------------------------------------------
// swam_check
// port-level checks for the sliding window anagram matcher
// ----------------------------------------------------------------------------
module swam_check (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input swam_pkg::in_word_t  item,
	input logic                result_valid,
	input logic                result_stall,
	input swam_pkg::out_word_t result
);
	import swam_pkg::*;

	// a held result word keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// a matching window always shows up as found
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.window_match |-> result.found)
		else $error("window match without found");

	// input backs up only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without a held result");

	// a fresh result comes from an accepted item word, through the input stage and the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result word without an accepted item word");

endmodule

bind sliding_window_anagram_match swam_check u_swam_check (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sliding window anagram matcher
// ----------------------------------------------------------------------------
// A queue of words is filled by the stimulus process and streamed through the
// item channel with random gaps. Every accepted word runs through a behavioral
// copy of the matcher (pattern and window histograms, ring of recent letters,
// count of differing letters). The resulting word is queued and compared with
// each word taken from the result channel. The stimulus starts with a short
// directed sequence and continues with random queries. One long receiver
// hold-off fills the block, and there are pauses until all results are back.
// ----------------------------------------------------------------------------
module tb_top;

	import swam_pkg::*;

	localparam int WINDOW     = 64;
	localparam int ALPHABET   = ALPHABET_SIZE;
	localparam int RAND_WORDS = 1050;
	localparam int LONG_HOLD  = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL       = 16;

	// kind code that the block has no use for
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b1;
	out_word_t result;

	sliding_window_anagram_match #(
		.MAX_WINDOW   (WINDOW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	in_word_t  word_backlog[$];
	out_word_t pending_outcomes[$];

	int  errors = 0;
	int  words_taken = 0;
	int  queries_taken = 0;
	int  results_seen = 0;
	int  match_count = 0;
	int  overflow_count = 0;
	bit  item_taken = 1'b0;
	bit  long_hold_go = 1'b0;
	bit  long_hold_started = 1'b0;
	int  hold_left = 0;
	int  rx_calm = 0;
	int  tx_gap = 0;
	int  tx_calm = 0;
	int  idle_cycles = 0;

	// behavioral copy of the matcher state
	logic [6:0] pat_hist[ALPHABET];
	logic [6:0] win_hist[ALPHABET];
	logic [4:0] recent[WINDOW];
	logic [6:0] pat_len;
	logic [6:0] win_fill;
	logic [5:0] wr_ptr;
	logic [4:0] diff_cnt;
	bit         hit_seen;
	bit         ovf_seen;

	function automatic void clear_query();
		for (int i = 0; i < ALPHABET; i++) begin
			pat_hist[i] = '0;
			win_hist[i] = '0;
		end
		pat_len  = '0;
		win_fill = '0;
		wr_ptr   = '0;
		diff_cnt = '0;
		hit_seen = 1'b0;
		ovf_seen = 1'b0;
	endfunction

	// move one histogram entry by one and track whether the letter now differs
	function automatic void adjust_hist(bit in_window, int idx, bit up);
		bit was_diff;
		bit now_diff;
		was_diff = pat_hist[idx] != win_hist[idx];
		if (in_window) begin
			if (up)
				win_hist[idx] = win_hist[idx] + 7'd1;
			else if (win_hist[idx] != 0)
				win_hist[idx] = win_hist[idx] - 7'd1;
		end else begin
			pat_hist[idx] = pat_hist[idx] + 7'd1;
		end
		now_diff = pat_hist[idx] != win_hist[idx];
		if (now_diff && !was_diff)
			diff_cnt = diff_cnt + 5'd1;
		else if (was_diff && !now_diff && diff_cnt != 0)
			diff_cnt = diff_cnt - 5'd1;
	endfunction

	// advance the state by one word and return the result word it yields
	function automatic out_word_t window_outcome(in_word_t w);
		out_word_t  r;
		bit         hit;
		logic [5:0] slot;
		logic [4:0] leaving;
		hit = 1'b0;
		case (w.kind)
			KIND_CLEAR: begin
				clear_query();
			end
			KIND_PATTERN: begin
				if (w.letter < ALPHABET && win_fill == 0 && wr_ptr == 0) begin
					if (pat_len >= WINDOW) begin
						ovf_seen = 1'b1;
					end else begin
						adjust_hist(1'b0, int'(w.letter), 1'b1);
						pat_len = pat_len + 7'd1;
					end
				end
			end
			KIND_TEXT: begin
				if (w.letter < ALPHABET) begin
					if (pat_len != 0) begin
						if (win_fill >= pat_len) begin
							// the letter pattern-length places back leaves the window
							slot    = wr_ptr - pat_len[5:0];
							leaving = recent[slot];
							adjust_hist(1'b1, int'(w.letter), 1'b1);
							if (leaving < ALPHABET)
								adjust_hist(1'b1, int'(leaving), 1'b0);
						end else begin
							adjust_hist(1'b1, int'(w.letter), 1'b1);
							win_fill = win_fill + 7'd1;
						end
						recent[wr_ptr] = w.letter;
						wr_ptr = wr_ptr + 6'd1;
						hit = (win_fill == pat_len) && (diff_cnt == 0);
					end else begin
						hit = 1'b1;
					end
					if (hit)
						hit_seen = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.window_match = hit;
		r.found        = hit_seen || (pat_len == 0);
		r.overflow     = ovf_seen;
		return r;
	endfunction

	function automatic void compare_bit(string what, logic want, logic got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %b, actual %b", $time, what, want, got);
		end
	endfunction

	// random pause length, with calm stretches that have no pauses at all
	function automatic int next_pause(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm = $urandom_range(20, 100);
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// predict on accepted items, check accepted results
	always @(posedge clk) begin : track_words
		out_word_t want;
		if (!arst_n) begin
			clear_query();
			for (int i = 0; i < WINDOW; i++)
				recent[i] = '0;
			item_taken <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result.window_match === 1'b1)
					match_count++;
				if (result.overflow === 1'b1)
					overflow_count++;
				if (pending_outcomes.size() == 0) begin
					errors++;
					$display("%0t: result word %b arrived with nothing expected",
						$time, result);
				end else begin
					want = pending_outcomes.pop_front();
					compare_bit("window_match", want.window_match, result.window_match);
					compare_bit("found", want.found, result.found);
					compare_bit("overflow", want.overflow, result.overflow);
				end
			end
			if (item_valid && !item_stall) begin
				words_taken++;
				if (item.kind == KIND_CLEAR)
					queries_taken++;
				pending_outcomes.push_back(window_outcome(item));
			end
			item_taken <= item_valid && !item_stall;
		end
	end

	// stop the run if neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// item side: offer words from the backlog, hold them while stalled
	always @(negedge clk) begin : drive_items
		logic     nv;
		in_word_t nw;
		nv = item_valid;
		nw = item;
		if (item_valid && item_taken) begin
			void'(word_backlog.pop_front());
			tx_gap = next_pause(tx_calm);
			nv = 1'b0;
		end
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!(item_valid && !item_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				nv = 1'b0;
			end else if (word_backlog.size() != 0) begin
				nv = 1'b1;
				nw = word_backlog[0];
			end else begin
				nv = 1'b0;
			end
		end
		item_valid <= nv;
		item       <= nw;
	end

	// result side: random stalls plus one long hold-off on request
	always @(negedge clk) begin : drive_stall
		logic stall_next;
		if (long_hold_go && !long_hold_started) begin
			long_hold_started = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_next = 1'b1;
		end else begin
			hold_left = next_pause(rx_calm);
			stall_next = hold_left > 0;
			if (hold_left > 0)
				hold_left--;
		end
		result_stall <= stall_next;
	end

	task automatic offer(input logic [KIND_W-1:0] k, input logic [LETTER_W-1:0] l);
		in_word_t w;
		w.kind   = k;
		w.letter = l;
		word_backlog.push_back(w);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (word_backlog.size() != 0 || item_valid || pending_outcomes.size() != 0);
	endtask

	// one query: clear, pattern, then text built from random letters and
	// shuffled copies of the pattern; returns the number of meaningful words
	task automatic add_query(input bit long_pattern, output int added);
		logic [LETTER_W-1:0] pat[$];
		logic [LETTER_W-1:0] perm[$];
		logic [LETTER_W-1:0] tmp;
		int plen;
		int tlen;
		int span;
		int base;
		int r;
		int j;
		int sent;
		added = 0;
		// now and then the clear is left out
		if ($urandom_range(0, 9) != 0) begin
			offer(KIND_CLEAR, 5'($urandom_range(0, 31)));
			added++;
		end
		r = $urandom_range(0, 99);
		if (long_pattern || r < 8)
			plen = $urandom_range(60, 68);
		else if (r < 14)
			plen = 0;
		else if (r < 25)
			plen = $urandom_range(7, 20);
		else
			plen = $urandom_range(1, 6);
		span = $urandom_range(2, ALPHABET);
		base = $urandom_range(0, ALPHABET - span);
		for (int i = 0; i < plen; i++) begin
			tmp = 5'(base + $urandom_range(0, span - 1));
			pat.push_back(tmp);
			offer(KIND_PATTERN, tmp);
			added++;
			if ($urandom_range(0, 49) == 0)
				offer(KIND_PATTERN, 5'($urandom_range(ALPHABET, 31)));
		end
		if (plen >= 60)
			tlen = $urandom_range(60, 140);
		else if ($urandom_range(0, 4) == 0)
			tlen = $urandom_range(70, 150);
		else
			tlen = $urandom_range(plen, 4 * plen + 10);
		sent = 0;
		while (sent < tlen) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				offer(KIND_NONE, 5'($urandom_range(0, 31)));
			end else if (r < 4) begin
				offer(KIND_TEXT, 5'($urandom_range(ALPHABET, 31)));
			end else if (r < 5) begin
				offer(KIND_PATTERN, 5'($urandom_range(0, 31)));
			end else if (r < 25 && pat.size() != 0) begin
				perm = pat;
				for (int i = perm.size() - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				foreach (perm[i])
					offer(KIND_TEXT, perm[i]);
				sent += perm.size();
			end else begin
				offer(KIND_TEXT, 5'(base + $urandom_range(0, span - 1)));
				sent++;
			end
		end
		added += sent;
	endtask

	initial begin : stimulus
		int rand_words;
		int added;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pattern, letters at both ends of the range, letters
		// out of range, the unused kind, pattern letters after text, matches
		offer(KIND_CLEAR, 5'd31);
		offer(KIND_TEXT, 5'd0);
		offer(KIND_NONE, 5'd31);
		offer(KIND_PATTERN, 5'd0);
		offer(KIND_PATTERN, 5'd25);
		offer(KIND_PATTERN, 5'd26);
		offer(KIND_TEXT, 5'd25);
		offer(KIND_TEXT, 5'd0);
		offer(KIND_PATTERN, 5'd1);
		offer(KIND_TEXT, 5'd30);
		offer(KIND_TEXT, 5'd1);
		offer(KIND_TEXT, 5'd25);
		offer(KIND_TEXT, 5'd0);
		offer(KIND_NONE, 5'd0);
		offer(KIND_CLEAR, 5'd0);
		offer(KIND_PATTERN, 5'd3);
		offer(KIND_TEXT, 5'd3);
		offer(KIND_TEXT, 5'd4);
		offer(KIND_TEXT, 5'd3);
		offer(KIND_CLEAR, 5'd21);
		wait_drained();

		// long receiver hold-off while a query with a long pattern, which may overflow, streams in
		long_hold_go = 1'b1;
		rand_words = 0;
		add_query(1'b1, added);
		rand_words += added;
		add_query(1'b0, added);
		rand_words += added;
		wait_drained();

		// random queries, with an occasional pause until all results are back
		while (rand_words < RAND_WORDS) begin
			add_query(1'b0, added);
			rand_words += added;
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (TAIL) @(posedge clk);

		$display("run covered %0d words in %0d queries, %0d results checked",
			words_taken, queries_taken, results_seen);
		$display("window matches seen: %0d, results with overflow flagged: %0d",
			match_count, overflow_count);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
